[hw/rtl/miq_pkg.sv]
// shared types and codes for the middle-insert queue
`timescale 1ns / 1ps

package miq_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int ITEM_W       = 32;

    // operation codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;

    // result status codes
    localparam logic [1:0] STS_PUSH_DONE = 2'd0;
    localparam logic [1:0] STS_POP_DONE  = 2'd1;
    localparam logic [1:0] STS_POP_EMPTY = 2'd2;
    localparam logic [1:0] STS_PUSH_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ITEM_W-1:0] item_value;
    } in_item_t;

    typedef struct packed {
        logic [ITEM_W-1:0] popped_value;
        logic [1:0]        status;
    } out_item_t;

    // memory operations planned for one transaction
    typedef struct packed {
        logic       front_we;
        logic       back_we;
        logic       front_re;
        logic       back_re;
        logic       move_we;
        logic       move_fwd;
        logic [1:0] status;
    } plan_t;

endpackage

[hw/rtl/middle_insert_queue.sv]
// top level of the middle-insert queue: two half memories, sequencer, result register
`timescale 1ns / 1ps

// Queue of 32-bit identifiers supporting append at tail, insert at the middle
// (after the first ceil(n/2) items) and pop of the head; every transaction in gives
// one result transaction out. The queue is held as a front half and a back half,
// each a ring in its own memory with registered read data. A transaction runs in
// ST_IDLE, which issues the memory reads and the insert write, and then in ST_MOVE,
// which takes the read data, does any rebalancing write into the front memory and
// loads the result register once that register drains; a new transaction is taken
// only after the previous one has completed. The memories need no clearing after
// reset; only entries that were written are ever read.

module middle_insert_queue #(
    parameter int  CAPACITY = miq_pkg::CAPACITY_DEF,
    localparam int PTR_W    = $clog2(CAPACITY)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  miq_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output miq_pkg::out_item_t m_data
);

    typedef enum logic {
        ST_IDLE,
        ST_MOVE
    } state_t;

    state_t                       state_reg;
    logic                         m_valid_reg;
    miq_pkg::out_item_t           m_data_reg;
    miq_pkg::plan_t               plan;
    miq_pkg::plan_t               plan_reg;
    logic [miq_pkg::ITEM_W-1:0]   item_reg;
    logic [PTR_W-1:0]             move_addr_reg;

    logic                         s_accept;
    logic                         move_fire;
    logic [PTR_W-1:0]             front_waddr_c;
    logic [PTR_W-1:0]             back_waddr_c;
    logic [PTR_W-1:0]             front_raddr_c;
    logic [PTR_W-1:0]             back_raddr_c;
    logic [PTR_W-1:0]             move_addr_c;

    logic                         front_we;
    logic [PTR_W-1:0]             front_waddr;
    logic [miq_pkg::ITEM_W-1:0]   front_wdata;
    logic [miq_pkg::ITEM_W-1:0]   front_rdata;
    logic [miq_pkg::ITEM_W-1:0]   back_rdata;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    // ST_MOVE completes only once the result register is free or being drained
    assign move_fire = (state_reg == ST_MOVE) && (!m_valid_reg || m_ready);

    miq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .item        (s_data),
        .plan        (plan),
        .front_waddr (front_waddr_c),
        .back_waddr  (back_waddr_c),
        .front_raddr (front_raddr_c),
        .back_raddr  (back_raddr_c),
        .move_addr   (move_addr_c)
    );

    assign front_we    = (s_accept && plan.front_we) || (move_fire && plan_reg.move_we);
    assign front_waddr = move_fire ? move_addr_reg : front_waddr_c;
    assign front_wdata = move_fire ? (plan_reg.move_fwd ? item_reg : back_rdata)
                                   : s_data.item_value;

    miq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (miq_pkg::ITEM_W)
    ) u_front_ram (
        .aclk  (aclk),
        .we    (front_we),
        .waddr (front_waddr),
        .wdata (front_wdata),
        .re    (s_accept && plan.front_re),
        .raddr (front_raddr_c),
        .rdata (front_rdata)
    );

    miq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (miq_pkg::ITEM_W)
    ) u_back_ram (
        .aclk  (aclk),
        .we    (s_accept && plan.back_we),
        .waddr (back_waddr_c),
        .wdata (s_data.item_value),
        .re    (s_accept && plan.back_re),
        .raddr (back_raddr_c),
        .rdata (back_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg     <= ST_MOVE;
                        plan_reg      <= plan;
                        item_reg      <= s_data.item_value;
                        move_addr_reg <= move_addr_c;
                    end
                end
                ST_MOVE: begin
                    if (move_fire) begin
                        state_reg               <= ST_IDLE;
                        m_data_reg.status       <= plan_reg.status;
                        m_data_reg.popped_value <= plan_reg.front_re ? front_rdata : '0;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (move_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // one transaction in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("transaction accepted while another is in progress");

    // anything but a successful pop returns zero
    a_zero_unless_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != miq_pkg::STS_POP_DONE |-> m_data.popped_value == '0)
        else $error("nonzero value on a result that is not a pop");

    // rebalancing write only follows a transaction that changed the queue
    a_move_on_success: assert property (@(posedge aclk) disable iff (!aresetn)
        move_fire && plan_reg.move_we |->
            (plan_reg.status == miq_pkg::STS_PUSH_DONE ||
             plan_reg.status == miq_pkg::STS_POP_DONE))
        else $error("rebalancing write after a refused transaction");

    // a result appears the cycle after the second step completes
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        move_fire |=> m_valid && s_ready)
        else $error("result not presented after completing a transaction");

endmodule

[hw/rtl/miq_ram.sv]
// single-port-write, single-port-read memory with registered read data
`timescale 1ns / 1ps

module miq_ram #(
    parameter int  DEPTH = miq_pkg::CAPACITY_DEF,
    parameter int  WIDTH = miq_pkg::ITEM_W,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/miq_ctrl.sv]
// head and count bookkeeping for both halves, plans the memory accesses
`timescale 1ns / 1ps

module miq_ctrl #(
    parameter int  CAPACITY = miq_pkg::CAPACITY_DEF,
    localparam int PTR_W    = $clog2(CAPACITY),
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  miq_pkg::in_item_t  item,
    output miq_pkg::plan_t     plan,
    output logic [PTR_W-1:0]   front_waddr,
    output logic [PTR_W-1:0]   back_waddr,
    output logic [PTR_W-1:0]   front_raddr,
    output logic [PTR_W-1:0]   back_raddr,
    output logic [PTR_W-1:0]   move_addr
);

    localparam logic [CNT_W:0]   CAP_S  = (CNT_W + 1)'(CAPACITY);
    localparam logic [PTR_W-1:0] CAP_M1 = PTR_W'(CAPACITY - 1);

    logic [PTR_W-1:0] front_head_reg, front_head_next;
    logic [PTR_W-1:0] back_head_reg,  back_head_next;
    logic [CNT_W-1:0] front_count_reg, front_count_next;
    logic [CNT_W-1:0] back_count_reg,  back_count_next;

    logic [CNT_W:0]   total;
    logic             full;
    logic             f_eq_b;
    logic             f_gt_b;
    logic [PTR_W-1:0] front_tail;
    logic [PTR_W-1:0] back_tail;
    logic [PTR_W-1:0] back_prev;
    logic [PTR_W-1:0] front_head_inc;
    logic [PTR_W-1:0] back_head_inc;

    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (s >= CAP_S) begin
            s = s - CAP_S;
        end
        return s[PTR_W-1:0];
    endfunction

    assign total  = {1'b0, front_count_reg} + {1'b0, back_count_reg};
    assign full   = (total >= CAP_S);
    assign f_eq_b = (front_count_reg == back_count_reg);
    assign f_gt_b = ({1'b0, front_count_reg} == ({1'b0, back_count_reg} + (CNT_W + 1)'(1)));

    assign front_tail     = ring_add(front_head_reg, front_count_reg);
    assign back_tail      = ring_add(back_head_reg, back_count_reg);
    assign front_head_inc = ring_add(front_head_reg, CNT_W'(1));
    assign back_head_inc  = ring_add(back_head_reg, CNT_W'(1));
    assign back_prev      = (back_head_reg == '0) ? CAP_M1 : back_head_reg - PTR_W'(1);

    always_comb begin
        plan             = '0;
        front_head_next  = front_head_reg;
        back_head_next   = back_head_reg;
        front_count_next = front_count_reg;
        back_count_next  = back_count_reg;
        front_waddr      = front_tail;
        back_waddr       = back_tail;
        front_raddr      = front_head_reg;
        back_raddr       = back_head_reg;
        // rebalancing write to the front tail always lands at head + count
        move_addr        = front_tail;

        priority if (item.operation == miq_pkg::OP_APPEND ||
                     item.operation == miq_pkg::OP_INSERT) begin
            if (full) begin
                plan.status = miq_pkg::STS_PUSH_FULL;
            end else begin
                plan.status = miq_pkg::STS_PUSH_DONE;
                if (item.operation == miq_pkg::OP_APPEND) begin
                    plan.back_we = 1'b1;
                    if (f_eq_b) begin
                        // back head (or the new item, if the back half is empty) shifts over to the front tail
                        plan.move_we     = 1'b1;
                        plan.move_fwd    = (back_count_reg == '0);
                        plan.back_re     = (back_count_reg != '0);
                        back_head_next   = back_head_inc;
                        front_count_next = front_count_reg + CNT_W'(1);
                    end else begin
                        back_count_next  = back_count_reg + CNT_W'(1);
                    end
                end else begin
                    if (f_gt_b) begin
                        // new item goes straight to the back head
                        plan.back_we     = 1'b1;
                        back_waddr       = back_prev;
                        back_head_next   = back_prev;
                        back_count_next  = back_count_reg + CNT_W'(1);
                    end else begin
                        plan.front_we    = 1'b1;
                        front_count_next = front_count_reg + CNT_W'(1);
                    end
                end
            end
        end else begin
            if (front_count_reg == '0) begin
                plan.status = miq_pkg::STS_POP_EMPTY;
            end else begin
                plan.status     = miq_pkg::STS_POP_DONE;
                plan.front_re   = 1'b1;
                front_head_next = front_head_inc;
                if (f_eq_b) begin
                    plan.back_re     = 1'b1;
                    plan.move_we     = 1'b1;
                    back_head_next   = back_head_inc;
                    back_count_next  = back_count_reg - CNT_W'(1);
                end else begin
                    front_count_next = front_count_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_head_reg  <= '0;
            back_head_reg   <= '0;
            front_count_reg <= '0;
            back_count_reg  <= '0;
        end else if (accept) begin
            front_head_reg  <= front_head_next;
            back_head_reg   <= back_head_next;
            front_count_reg <= front_count_next;
            back_count_reg  <= back_count_next;
        end
    end

endmodule
